// ===== rtl/core/ftxlr_pkg.sv =====
// Shared constants for the four-tap XOR lagged generator.
// Used by ftxlr_rem and four_tap_xor_lagged_rng_top; no dependencies.
package ftxlr_pkg;

  localparam int unsigned WORD_W = 31;
  localparam int unsigned TABLE_DEPTH = 16384;
  localparam int unsigned NUM_TAPS = 4;

  // Distances behind the write slot of the four words that are combined.
  localparam int unsigned LAGS [NUM_TAPS] = '{471, 1586, 6988, 9689};

  // Minimal-standard congruential step used for the table fill.
  localparam int unsigned MULT_W = 15;
  localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
  localparam logic [WORD_W-1:0] LCG_MOD = 31'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] SEED_RESET = 31'd1;

endpackage

// ===== rtl/core/ftxlr_rem.sv =====
// Bit-serial restoring remainder unit, one quotient bit per cycle.
// Depends on ftxlr_pkg for the word width.
module ftxlr_rem (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [ftxlr_pkg::WORD_W-1:0]   dividend_i,
  input  logic [ftxlr_pkg::WORD_W-1:0]   divisor_i,
  output logic                           done_o,
  output logic [ftxlr_pkg::WORD_W-1:0]   rem_o
);

  localparam int unsigned W = ftxlr_pkg::WORD_W;
  localparam int unsigned CntW = $clog2(W);
  localparam logic [CntW-1:0] LastStep = CntW'(W - 1);

  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    dvd_q, dvd_d;
  logic [W-1:0]    div_q, div_d;
  logic [W:0]      trial;
  logic [W:0]      diff;

  // A zero divisor always passes the compare, so the dividend comes out unchanged.
  assign trial = {rem_q, dvd_q[W-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      dvd_d = dividend_i;
      div_d = divisor_i;
    end else if (run_q) begin
      rem_d = (trial >= {1'b0, div_q}) ? diff[W-1:0] : trial[W-1:0];
      dvd_d = {dvd_q[W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/four_tap_xor_lagged_rng_top.sv =====
// Top level of the four-tap XOR lagged generator: lag table memory and sequencer.
// Depends on ftxlr_pkg and instantiates ftxlr_rem.
//
// Usage: after reset and after every seed transfer the block fills its 16384-word
// table with the congruential sequence, a multiply state and then a write state for
// each word, and holds busy high meanwhile. A draw is accepted when start is high and busy is low.
// A seed transfer is taken only while the block is idle and start is low.
// After acceptance the draw runs the serial table reads, the write-back state, the
// bit-serial remainder unit and the result register, in that order; then done_o rises.
// The result is shown for exactly one cycle with done_o high;
// the receiver cannot stall it and must capture it in that cycle. A new draw may be
// started in the same cycle that done_o is high.
module four_tap_xor_lagged_rng_top #(
  parameter int unsigned TableDepth = ftxlr_pkg::TABLE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [ftxlr_pkg::WORD_W-1:0]  modulus_i,
  input  logic                          seed_valid_i,
  output logic                          seed_ready_o,
  input  logic [ftxlr_pkg::WORD_W-1:0]  seed_value_i,
  output logic                          done_o,
  output logic [ftxlr_pkg::WORD_W-1:0]  raw_value_o,
  output logic [ftxlr_pkg::WORD_W-1:0]  reduced_value_o
);

  localparam int unsigned W = ftxlr_pkg::WORD_W;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned ProdW = W + ftxlr_pkg::MULT_W;
  localparam int unsigned TapW = $clog2(ftxlr_pkg::NUM_TAPS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableDepth - 1);
  localparam logic [TapW:0] ReadDone = (TapW + 1)'(ftxlr_pkg::NUM_TAPS);

  typedef enum logic [2:0] {
    S_FILL_MUL,
    S_FILL_WR,
    S_IDLE,
    S_READ,
    S_WRITE,
    S_DIV
  } state_e;

  state_e          state_q;
  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] fill_idx_q;
  logic [TapW:0]   rd_cnt_q;
  logic [W-1:0]    w_q;
  logic [ProdW-1:0] prod_q;
  logic [W-1:0]    acc_q;
  logic [W-1:0]    mod_q;
  logic            done_q;
  logic [W-1:0]    reduced_q;

  logic [W-1:0]    lag_table_q [TableDepth];
  logic [W-1:0]    rd_data_q;
  logic [IdxW-1:0] rd_addr;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [W-1:0]    wr_data;

  logic [W:0]      fold;
  logic [W:0]      fold_sub;
  logic [W-1:0]    w_next;
  logic            accept;
  logic            rem_done;
  logic [W-1:0]    rem_val;

  assign accept       = start && (state_q == S_IDLE);
  assign busy         = (state_q != S_IDLE);
  assign seed_ready_o = (state_q == S_IDLE) && !start;

  // Reduction modulo 2^31-1: the high part of the product folds onto the low part,
  // and the sum stays below twice the modulus.
  assign fold     = {1'b0, prod_q[W-1:0]} + (W + 1)'(prod_q[ProdW-1:W]);
  assign fold_sub = fold - {1'b0, ftxlr_pkg::LCG_MOD};
  assign w_next   = (fold >= {1'b0, ftxlr_pkg::LCG_MOD}) ? fold_sub[W-1:0] : fold[W-1:0];

  assign rd_addr = idx_q - IdxW'(ftxlr_pkg::LAGS[rd_cnt_q[TapW-1:0]]);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = acc_q;
    if (state_q == S_FILL_WR) begin
      wr_en   = 1'b1;
      wr_addr = fill_idx_q;
      wr_data = w_next;
    end else if (state_q == S_WRITE) begin
      wr_en = 1'b1;
    end
  end

  // The write slot never coincides with a tap address, and reads and the write of a
  // draw happen in separate cycles, so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lag_table_q[wr_addr] <= wr_data;
    end
    rd_data_q <= lag_table_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_FILL_MUL;
      idx_q      <= '0;
      fill_idx_q <= '0;
      rd_cnt_q   <= '0;
      w_q        <= ftxlr_pkg::SEED_RESET;
      done_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_FILL_MUL: begin
          state_q <= S_FILL_WR;
        end
        S_FILL_WR: begin
          w_q        <= w_next;
          fill_idx_q <= fill_idx_q + 1'b1;
          state_q    <= (fill_idx_q == LastIdx) ? S_IDLE : S_FILL_MUL;
        end
        S_IDLE: begin
          if (start) begin
            idx_q    <= idx_q + 1'b1;
            rd_cnt_q <= '0;
            state_q  <= S_READ;
          end else if (seed_valid_i) begin
            w_q        <= seed_value_i;
            fill_idx_q <= '0;
            state_q    <= S_FILL_MUL;
          end
        end
        S_READ: begin
          rd_cnt_q <= rd_cnt_q + 1'b1;
          if (rd_cnt_q == ReadDone) begin
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (rem_done) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers; the XOR accumulator picks up each read in the cycle after its issue.
  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(w_q) * ProdW'(ftxlr_pkg::LCG_MULT);
    if (accept) begin
      acc_q <= '0;
      mod_q <= modulus_i;
    end else if (state_q == S_READ && rd_cnt_q != '0) begin
      acc_q <= acc_q ^ rd_data_q;
    end
    if (state_q == S_DIV && rem_done) begin
      reduced_q <= rem_val;
    end
  end

  ftxlr_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_WRITE),
    .dividend_i (acc_q),
    .divisor_i  (mod_q),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  assign done_o          = done_q;
  assign raw_value_o     = acc_q;
  assign reduced_value_o = reduced_q;

endmodule

// ===== tb/tb_four_tap_xor_lagged_rng_top.sv =====
// Self-checking testbench for four_tap_xor_lagged_rng_top: a table of directed draws
// and seed writes, then randomized phases; draws are checked against an internal predictor or their typed result.
// Depends on ftxlr_pkg and the RTL of four_tap_xor_lagged_rng_top.
module tb_four_tap_xor_lagged_rng_top;

  localparam int unsigned WORD_W = ftxlr_pkg::WORD_W;
  localparam int unsigned TABLE_DEPTH = ftxlr_pkg::TABLE_DEPTH;
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned NUM_PHASES = 5;
  localparam int unsigned DRAWS_PER_PHASE = 320;
  localparam int unsigned NUM_DIRECTED = 24;
  localparam logic [WORD_W-1:0] WORD_MAX = '1;

  typedef struct packed {
    logic [WORD_W-1:0] raw;
    logic [WORD_W-1:0] reduced;
  } draw_result_t;

  typedef enum logic {
    ROW_DRAW,
    ROW_SEED
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [WORD_W-1:0] value;
    logic              typed;
    logic [WORD_W-1:0] raw;
    logic [WORD_W-1:0] reduced;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [WORD_W-1:0] modulus_i = '0;
  logic              seed_valid_i = 1'b0;
  logic              seed_ready_o;
  logic [WORD_W-1:0] seed_value_i = '0;
  logic              done_o;
  logic [WORD_W-1:0] raw_value_o;
  logic [WORD_W-1:0] reduced_value_o;

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;

  // Predictor state: its own copy of the lag table and the write slot.
  logic [WORD_W-1:0] lag_words [TABLE_DEPTH];
  logic [IDX_W-1:0]  draw_slot;
  draw_result_t      pending_draws [$];

  // Rows with a typed result are the ones drawn from an all-zero table.
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{ROW_DRAW, 31'd1,          1'b0, '0, '0},
    '{ROW_DRAW, 31'h7FFF_FFFF,  1'b0, '0, '0},
    '{ROW_DRAW, 31'd0,          1'b0, '0, '0},
    '{ROW_DRAW, 31'd2,          1'b0, '0, '0},
    '{ROW_DRAW, 31'd3,          1'b0, '0, '0},
    '{ROW_DRAW, 31'h5555_5555,  1'b0, '0, '0},
    '{ROW_DRAW, 31'h2AAA_AAAA,  1'b0, '0, '0},
    '{ROW_DRAW, 31'h4000_0000,  1'b0, '0, '0},
    '{ROW_SEED, 31'd0,          1'b0, '0, '0},
    '{ROW_DRAW, 31'd7,          1'b1, '0, '0},
    '{ROW_DRAW, 31'd0,          1'b1, '0, '0},
    '{ROW_DRAW, 31'h7FFF_FFFF,  1'b1, '0, '0},
    '{ROW_SEED, 31'h7FFF_FFFF,  1'b0, '0, '0},
    '{ROW_DRAW, 31'd1,          1'b1, '0, '0},
    '{ROW_DRAW, 31'd12345,      1'b1, '0, '0},
    '{ROW_SEED, 31'h7FFF_FFFE,  1'b0, '0, '0},
    '{ROW_DRAW, 31'd1,          1'b0, '0, '0},
    '{ROW_DRAW, 31'h7FFF_FFFF,  1'b0, '0, '0},
    '{ROW_DRAW, 31'd0,          1'b0, '0, '0},
    '{ROW_DRAW, 31'd65536,      1'b0, '0, '0},
    '{ROW_DRAW, 31'd1000003,    1'b0, '0, '0},
    '{ROW_SEED, 31'd1,          1'b0, '0, '0},
    '{ROW_DRAW, 31'd16383,      1'b0, '0, '0},
    '{ROW_DRAW, 31'h3FFF_FFFF,  1'b0, '0, '0}
  };

  four_tap_xor_lagged_rng_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .modulus_i      (modulus_i),
    .seed_valid_i   (seed_valid_i),
    .seed_ready_o   (seed_ready_o),
    .seed_value_i   (seed_value_i),
    .done_o         (done_o),
    .raw_value_o    (raw_value_o),
    .reduced_value_o(reduced_value_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Congruential fill, done in 64 bits so that the product never overflows.
  function automatic void refill_lag_words(input logic [WORD_W-1:0] seed);
    logic [63:0] word;
    word = (64'(ftxlr_pkg::LCG_MULT) * 64'(seed)) % 64'(ftxlr_pkg::LCG_MOD);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      lag_words[i] = word[WORD_W-1:0];
      word = (64'(ftxlr_pkg::LCG_MULT) * word) % 64'(ftxlr_pkg::LCG_MOD);
    end
  endfunction

  function automatic draw_result_t predict_draw(input logic [WORD_W-1:0] modulus);
    draw_result_t     res;
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  tap_slot;
    draw_slot = draw_slot + 1'b1;
    word = '0;
    for (int t = 0; t < ftxlr_pkg::NUM_TAPS; t++) begin
      tap_slot = draw_slot - IDX_W'(ftxlr_pkg::LAGS[t]);
      word ^= lag_words[tap_slot];
    end
    lag_words[draw_slot] = word;
    res.raw = word;
    // A zero divisor leaves the dividend untouched in the serial remainder unit.
    res.reduced = (modulus == '0) ? word : word % modulus;
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] pick_modulus();
    logic [4:0] shift;
    shift = 5'($urandom_range(0, WORD_W - 1));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return WORD_W'($urandom);
      4, 5:       return WORD_W'($urandom_range(1, 1000));
      6:          return WORD_W'(1) << shift;
      7:          return (WORD_W'(1) << shift) - 1'b1;
      8:          return WORD_MAX - WORD_W'($urandom_range(0, 1000));
      default:    return WORD_W'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic issue_draw(input logic [WORD_W-1:0] modulus, input int unsigned gap,
                            input logic typed, input draw_result_t typed_res);
    draw_result_t res;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    modulus_i <= modulus;
    do @(posedge clk_i); while (busy);
    res = predict_draw(modulus);
    pending_draws.push_back(typed ? typed_res : res);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES + $urandom_range(0, 5)) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [WORD_W-1:0] seed);
    wait_idle();
    seed_valid_i <= 1'b1;
    seed_value_i <= seed;
    do @(posedge clk_i); while (!seed_ready_o);
    seed_valid_i <= 1'b0;
    refill_lag_words(seed);
  endtask

  // Results cannot be held off, so each strobe is compared on the edge that ends it.
  always @(posedge clk_i) begin
    draw_result_t want;
    if (rst_ni && done_o) begin
      if (pending_draws.size() == 0) begin
        $error("result with no draw pending: raw_value %h reduced_value %h",
               raw_value_o, reduced_value_o);
        mismatch_count++;
      end else begin
        want = pending_draws.pop_front();
        if (raw_value_o !== want.raw) begin
          $error("raw_value mismatch: expected %h, actual %h", want.raw, raw_value_o);
          mismatch_count++;
        end
        if (reduced_value_o !== want.reduced) begin
          $error("reduced_value mismatch: expected %h, actual %h",
                 want.reduced, reduced_value_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic              idle_on;
    logic [WORD_W-1:0] seed;
    refill_lag_words(ftxlr_pkg::SEED_RESET);
    draw_slot = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_SEED) begin
        write_seed(directed_rows[r].value);
      end else begin
        issue_draw(directed_rows[r].value, $urandom_range(0, 5), directed_rows[r].typed,
                   {directed_rows[r].raw, directed_rows[r].reduced});
      end
    end

    idle_on = 1'b1;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        1:       seed = WORD_MAX - 1'b1;
        3:       seed = WORD_W'(1);
        default: seed = WORD_W'($urandom_range(32'd2147483646, 32'd0));
      endcase
      write_seed(seed);
      for (int i = 0; i < DRAWS_PER_PHASE; i++) begin
        // Each stretch of 32 draws is either back-to-back or has random gaps.
        if (i % 32 == 0) begin
          idle_on = ($urandom_range(0, 2) != 0);
        end
        issue_draw(pick_modulus(), idle_on ? $urandom_range(0, 5) : 0, 1'b0, '0);
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
